### hdl/rti_pkg.sv
// Shared constants, types and width helpers for the ray/triangle intersection block.
package rti_pkg;

    localparam int DEF_COORD_WIDTH = 16;
    localparam int EPS_W           = 56;
    localparam int DIST_W          = 32;
    localparam int UV_W            = 17;
    localparam int TAG_W           = 16;
    localparam int QUOT_FRAC       = 16;
    localparam int QUOT_BITS       = 33;
    localparam int LANES           = 3;
    localparam int ADDR_W          = 3;

    localparam logic [ADDR_W-1:0] REG_ORIGIN    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DIRECTION = 3'd1;
    localparam logic [ADDR_W-1:0] REG_MIN_DIST  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_DIST  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_EPSILON   = 3'd4;

    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int LANE_T = 2;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 32'h7FFF_FFFF;
    localparam logic [EPS_W-1:0]  EPS_RESET      = 56'd1;

    typedef struct packed {
        logic             pass;
        logic             tneg;
        logic [TAG_W-1:0] tag;
    } t_side;

    function automatic int sum_width(input int cw);
        return (3 * cw + 6 > 64) ? 64 : 3 * cw + 6;
    endfunction

    function automatic int cfg_width(input int cw);
        return (3 * cw > EPS_W) ? 3 * cw : EPS_W;
    endfunction

endpackage

### hdl/rti_geom.sv
// Five-stage edge, cross and dot product pipeline producing det, u, v and t numerators.
module rti_geom #(
    parameter int CW = 16,
    parameter int SW = 54
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [CW-1:0]             i_vtx [0:8],
    input  logic [rti_pkg::TAG_W-1:0]        i_tag,
    input  logic [3*CW-1:0]                  i_origin,
    input  logic [3*CW-1:0]                  i_direction,
    output logic                             o_valid,
    output logic signed [SW-1:0]             o_det,
    output logic signed [SW-1:0]             o_un,
    output logic signed [SW-1:0]             o_vn,
    output logic signed [SW-1:0]             o_tn,
    output logic [rti_pkg::TAG_W-1:0]        o_tag
);

    localparam int EW  = CW + 1;
    localparam int PHW = 2 * CW + 1;
    localparam int PQW = 2 * CW + 2;
    localparam int HW  = 2 * CW + 2;
    localparam int QW  = 2 * CW + 3;
    localparam int PW  = 3 * CW + 4;
    localparam int AW  = 3 * CW + 6;

    // stage 1: edges and origin offset
    logic signed [EW-1:0]  n1_e1 [0:2];
    logic signed [EW-1:0]  n1_e2 [0:2];
    logic signed [EW-1:0]  n1_s  [0:2];
    logic signed [CW-1:0]  n1_dir [0:2];
    logic signed [EW-1:0]  r1_e1 [0:2];
    logic signed [EW-1:0]  r1_e2 [0:2];
    logic signed [EW-1:0]  r1_s  [0:2];
    logic signed [CW-1:0]  r1_dir [0:2];
    logic                  r1_valid;
    logic [rti_pkg::TAG_W-1:0] r1_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_dir[i] = signed'(i_direction[i*CW +: CW]);
            n1_e1[i]  = EW'(i_vtx[3+i]) - EW'(i_vtx[i]);
            n1_e2[i]  = EW'(i_vtx[6+i]) - EW'(i_vtx[i]);
            n1_s[i]   = EW'(signed'(i_origin[i*CW +: CW])) - EW'(i_vtx[i]);
        end
    end

    // stage 2: cross product terms
    logic signed [PHW-1:0] n2_hp [0:5];
    logic signed [PQW-1:0] n2_qp [0:5];
    logic signed [PHW-1:0] r2_hp [0:5];
    logic signed [PQW-1:0] r2_qp [0:5];
    logic signed [EW-1:0]  r2_e1 [0:2];
    logic signed [EW-1:0]  r2_e2 [0:2];
    logic signed [EW-1:0]  r2_s  [0:2];
    logic signed [CW-1:0]  r2_dir [0:2];
    logic                  r2_valid;
    logic [rti_pkg::TAG_W-1:0] r2_tag;

    for (genvar g = 0; g < 3; g++) begin : g_cross
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        assign n2_hp[2*g]   = PHW'(r1_dir[J]) * PHW'(r1_e2[K]);
        assign n2_hp[2*g+1] = PHW'(r1_dir[K]) * PHW'(r1_e2[J]);
        assign n2_qp[2*g]   = PQW'(r1_s[J]) * PQW'(r1_e1[K]);
        assign n2_qp[2*g+1] = PQW'(r1_s[K]) * PQW'(r1_e1[J]);
    end

    // stage 3: cross product differences
    logic signed [HW-1:0] n3_h [0:2];
    logic signed [QW-1:0] n3_q [0:2];
    logic signed [HW-1:0] r3_h [0:2];
    logic signed [QW-1:0] r3_q [0:2];
    logic signed [EW-1:0] r3_e1 [0:2];
    logic signed [EW-1:0] r3_e2 [0:2];
    logic signed [EW-1:0] r3_s  [0:2];
    logic signed [CW-1:0] r3_dir [0:2];
    logic                 r3_valid;
    logic [rti_pkg::TAG_W-1:0] r3_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_h[i] = HW'(r2_hp[2*i]) - HW'(r2_hp[2*i+1]);
            n3_q[i] = QW'(r2_qp[2*i]) - QW'(r2_qp[2*i+1]);
        end
    end

    // stage 4: dot product terms
    logic signed [PW-1:0] n4_det [0:2];
    logic signed [PW-1:0] n4_un  [0:2];
    logic signed [PW-1:0] n4_vn  [0:2];
    logic signed [PW-1:0] n4_tn  [0:2];
    logic signed [PW-1:0] r4_det [0:2];
    logic signed [PW-1:0] r4_un  [0:2];
    logic signed [PW-1:0] r4_vn  [0:2];
    logic signed [PW-1:0] r4_tn  [0:2];
    logic                 r4_valid;
    logic [rti_pkg::TAG_W-1:0] r4_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_det[i] = PW'(r3_e1[i]) * PW'(r3_h[i]);
            n4_un[i]  = PW'(r3_s[i]) * PW'(r3_h[i]);
            n4_vn[i]  = PW'(r3_dir[i]) * PW'(r3_q[i]);
            n4_tn[i]  = PW'(r3_e2[i]) * PW'(r3_q[i]);
        end
    end

    // stage 5: dot product sums, wrapped to the datapath width
    logic signed [AW-1:0] w_det;
    logic signed [AW-1:0] w_un;
    logic signed [AW-1:0] w_vn;
    logic signed [AW-1:0] w_tn;
    logic signed [SW-1:0] r5_det;
    logic signed [SW-1:0] r5_un;
    logic signed [SW-1:0] r5_vn;
    logic signed [SW-1:0] r5_tn;
    logic                 r5_valid;
    logic [rti_pkg::TAG_W-1:0] r5_tag;

    assign w_det = AW'(r4_det[0]) + AW'(r4_det[1]) + AW'(r4_det[2]);
    assign w_un  = AW'(r4_un[0]) + AW'(r4_un[1]) + AW'(r4_un[2]);
    assign w_vn  = AW'(r4_vn[0]) + AW'(r4_vn[1]) + AW'(r4_vn[2]);
    assign w_tn  = AW'(r4_tn[0]) + AW'(r4_tn[1]) + AW'(r4_tn[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_e1  <= n1_e1;
            r1_e2  <= n1_e2;
            r1_s   <= n1_s;
            r1_dir <= n1_dir;
            r1_tag <= i_tag;
            r2_hp  <= n2_hp;
            r2_qp  <= n2_qp;
            r2_e1  <= r1_e1;
            r2_e2  <= r1_e2;
            r2_s   <= r1_s;
            r2_dir <= r1_dir;
            r2_tag <= r1_tag;
            r3_h   <= n3_h;
            r3_q   <= n3_q;
            r3_e1  <= r2_e1;
            r3_e2  <= r2_e2;
            r3_s   <= r2_s;
            r3_dir <= r2_dir;
            r3_tag <= r2_tag;
            r4_det <= n4_det;
            r4_un  <= n4_un;
            r4_vn  <= n4_vn;
            r4_tn  <= n4_tn;
            r4_tag <= r3_tag;
            r5_det <= w_det[SW-1:0];
            r5_un  <= w_un[SW-1:0];
            r5_vn  <= w_vn[SW-1:0];
            r5_tn  <= w_tn[SW-1:0];
            r5_tag <= r4_tag;
        end
    end

    assign o_valid = r5_valid;
    assign o_det   = r5_det;
    assign o_un    = r5_un;
    assign o_vn    = r5_vn;
    assign o_tn    = r5_tn;
    assign o_tag   = r5_tag;

endmodule

### hdl/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module rti_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 54,
    parameter int QB    = 33,
    parameter int SB_W  = 18
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NUM_W-1:0]      i_num [0:rti_pkg::LANES-1],
    input  logic [DEN_W-1:0]      i_den,
    input  logic [SB_W-1:0]       i_side,
    output logic                  o_valid,
    output logic [QB-1:0]         o_quot [0:rti_pkg::LANES-1],
    output logic [DEN_W-1:0]      o_rem  [0:rti_pkg::LANES-1],
    output logic [SB_W-1:0]       o_side
);

    localparam int LN = rti_pkg::LANES;
    localparam int XW = NUM_W + rti_pkg::QUOT_FRAC;

    logic [DEN_W-1:0] r_rem  [0:QB-1][0:LN-1];
    logic [QB-1:0]    r_low  [0:QB-1][0:LN-1];
    logic [QB-1:0]    r_quot [0:QB-1][0:LN-1];
    logic [DEN_W-1:0] r_den  [0:QB-1];
    logic [SB_W-1:0]  r_side [0:QB-1];
    logic             r_valid [0:QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DEN_W-1:0] w_prem [0:LN-1];
        logic [QB-1:0]    w_plow [0:LN-1];
        logic [QB-1:0]    w_pquot [0:LN-1];
        logic [DEN_W-1:0] w_pden;
        logic [SB_W-1:0]  w_pside;
        logic             w_pvalid;
        logic [DEN_W-1:0] n_rem  [0:LN-1];
        logic [QB-1:0]    n_low  [0:LN-1];
        logic [QB-1:0]    n_quot [0:LN-1];

        if (k == 0) begin : g_first
            for (genvar l = 0; l < LN; l++) begin : g_lane
                logic [XW-1:0] w_dvd;
                assign w_dvd      = {i_num[l], {rti_pkg::QUOT_FRAC{1'b0}}};
                assign w_prem[l]  = DEN_W'(w_dvd >> QB);
                assign w_plow[l]  = w_dvd[QB-1:0];
                assign w_pquot[l] = '0;
            end
            assign w_pden   = i_den;
            assign w_pside  = i_side;
            assign w_pvalid = i_valid;
        end else begin : g_next
            assign w_prem   = r_rem[k-1];
            assign w_plow   = r_low[k-1];
            assign w_pquot  = r_quot[k-1];
            assign w_pden   = r_den[k-1];
            assign w_pside  = r_side[k-1];
            assign w_pvalid = r_valid[k-1];
        end

        for (genvar l = 0; l < LN; l++) begin : g_step
            logic [DEN_W:0] w_trial;
            logic [DEN_W:0] w_diff;
            logic           w_ge;
            assign w_trial   = {w_prem[l], w_plow[l][QB-1]};
            assign w_diff    = w_trial - {1'b0, w_pden};
            assign w_ge      = w_trial >= {1'b0, w_pden};
            assign n_rem[l]  = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            assign n_low[l]  = w_plow[l] << 1;
            assign n_quot[l] = {w_pquot[l][QB-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_pvalid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_quot[k] <= n_quot;
                r_den[k]  <= w_pden;
                r_side[k] <= w_pside;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_quot  = r_quot[QB-1];
    assign o_rem   = r_rem[QB-1];
    assign o_side  = r_side[QB-1];

endmodule

### hdl/ray_triangle_intersect.sv
// Top level of the Moller-Trumbore ray/triangle intersection pipeline.
// One triangle is accepted per clock unless the output stalls. Its result passes through five
// stages of edge, cross and dot products, one stage of sign fix-up and range tests, 33 stages
// of the shared-divisor divider (one quotient bit each, three lanes for u, v and t) and the
// output register. A stall at the output holds every stage; nothing inside ever waits otherwise.
// The ray registers feed the pipeline directly, so write them only while no triangle is in
// flight. Tests on det, u, v and t are exact; t, u and v are reported truncated.
module ray_triangle_intersect #(
    parameter int COORD_WIDTH = rti_pkg::DEF_COORD_WIDTH
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [rti_pkg::ADDR_W-1:0]                    i_cfg_addr,
    input  logic [rti_pkg::cfg_width(COORD_WIDTH)-1:0]    i_cfg_data,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex0_x,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex0_y,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex0_z,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex1_x,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex1_y,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex1_z,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex2_x,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex2_y,
    input  logic signed [COORD_WIDTH-1:0]                 i_vertex2_z,
    input  logic [rti_pkg::TAG_W-1:0]                     i_triangle_tag,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic                                          o_hit_flag,
    output logic signed [rti_pkg::DIST_W-1:0]             o_hit_distance,
    output logic [rti_pkg::UV_W-1:0]                      o_bary_u,
    output logic [rti_pkg::UV_W-1:0]                      o_bary_v,
    output logic [rti_pkg::TAG_W-1:0]                     o_result_tag
);

    localparam int SW  = rti_pkg::sum_width(COORD_WIDTH);
    localparam int EXW = (SW > rti_pkg::EPS_W) ? SW : rti_pkg::EPS_W;
    localparam int QB  = rti_pkg::QUOT_BITS;
    localparam int FLW = QB + 2;
    localparam int LN  = rti_pkg::LANES;
    localparam int SBW = $bits(rti_pkg::t_side);

    // ray registers
    logic [3*COORD_WIDTH-1:0]          r_origin;
    logic [3*COORD_WIDTH-1:0]          r_direction;
    logic signed [rti_pkg::DIST_W-1:0] r_min_dist;
    logic signed [rti_pkg::DIST_W-1:0] r_max_dist;
    logic [rti_pkg::EPS_W-1:0]         r_epsilon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin    <= '0;
            r_direction <= '0;
            r_min_dist  <= '0;
            r_max_dist  <= rti_pkg::MAX_DIST_RESET;
            r_epsilon   <= rti_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rti_pkg::REG_ORIGIN:    r_origin    <= i_cfg_data[3*COORD_WIDTH-1:0];
                rti_pkg::REG_DIRECTION: r_direction <= i_cfg_data[3*COORD_WIDTH-1:0];
                rti_pkg::REG_MIN_DIST:  r_min_dist  <= i_cfg_data[rti_pkg::DIST_W-1:0];
                rti_pkg::REG_MAX_DIST:  r_max_dist  <= i_cfg_data[rti_pkg::DIST_W-1:0];
                rti_pkg::REG_EPSILON:   r_epsilon   <= i_cfg_data[rti_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // geometry
    logic signed [COORD_WIDTH-1:0] w_vtx [0:8];
    logic                          w_g_valid;
    logic signed [SW-1:0]          w_det;
    logic signed [SW-1:0]          w_un;
    logic signed [SW-1:0]          w_vn;
    logic signed [SW-1:0]          w_tn;
    logic [rti_pkg::TAG_W-1:0]     w_g_tag;

    assign w_vtx[0] = i_vertex0_x;
    assign w_vtx[1] = i_vertex0_y;
    assign w_vtx[2] = i_vertex0_z;
    assign w_vtx[3] = i_vertex1_x;
    assign w_vtx[4] = i_vertex1_y;
    assign w_vtx[5] = i_vertex1_z;
    assign w_vtx[6] = i_vertex2_x;
    assign w_vtx[7] = i_vertex2_y;
    assign w_vtx[8] = i_vertex2_z;

    rti_geom #(
        .CW (COORD_WIDTH),
        .SW (SW)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_valid),
        .i_vtx       (w_vtx),
        .i_tag       (i_triangle_tag),
        .i_origin    (r_origin),
        .i_direction (r_direction),
        .o_valid     (w_g_valid),
        .o_det       (w_det),
        .o_un        (w_un),
        .o_vn        (w_vn),
        .o_tn        (w_tn),
        .o_tag       (w_g_tag)
    );

    // sign fix-up and exact range tests
    logic          w_neg;
    logic [SW-1:0] w_adet;
    logic [SW-1:0] w_aun;
    logic [SW-1:0] w_avn;
    logic [SW-1:0] w_atn;
    logic          w_tneg;
    logic [SW-1:0] w_tmag;
    logic [SW:0]   w_uv_sum;
    logic          w_det_ok;
    logic          w_u_ok;
    logic          w_v_ok;
    logic          w_t_fit;

    assign w_neg    = w_det[SW-1];
    assign w_adet   = w_neg ? SW'(0) - SW'(w_det) : SW'(w_det);
    assign w_aun    = w_neg ? SW'(0) - SW'(w_un)  : SW'(w_un);
    assign w_avn    = w_neg ? SW'(0) - SW'(w_vn)  : SW'(w_vn);
    assign w_atn    = w_neg ? SW'(0) - SW'(w_tn)  : SW'(w_tn);
    assign w_tneg   = w_atn[SW-1];
    assign w_tmag   = w_tneg ? SW'(0) - w_atn : w_atn;
    assign w_uv_sum = {1'b0, w_aun} + {1'b0, w_avn};
    assign w_det_ok = (w_adet != '0) && (EXW'(w_adet) >= EXW'(r_epsilon));
    assign w_u_ok   = !w_aun[SW-1] && (w_aun <= w_adet);
    assign w_v_ok   = !w_avn[SW-1] && (w_uv_sum <= {1'b0, w_adet});
    assign w_t_fit  = (w_tmag >> (QB - rti_pkg::QUOT_FRAC)) < w_adet;

    logic             r_c_valid;
    logic [SW-1:0]    r_c_num [0:LN-1];
    logic [SW-1:0]    r_c_den;
    rti_pkg::t_side   r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= w_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_num[rti_pkg::LANE_U] <= w_aun;
            r_c_num[rti_pkg::LANE_V] <= w_avn;
            r_c_num[rti_pkg::LANE_T] <= w_tmag;
            r_c_den                  <= w_adet;
            r_c_side.pass            <= w_det_ok && w_u_ok && w_v_ok && w_t_fit;
            r_c_side.tneg            <= w_tneg;
            r_c_side.tag             <= w_g_tag;
        end
    end

    // quotients
    logic             w_d_valid;
    logic [QB-1:0]    w_quot [0:LN-1];
    logic [SW-1:0]    w_rem  [0:LN-1];
    logic [SBW-1:0]   w_d_side_bits;
    rti_pkg::t_side   w_d_side;

    rti_div #(
        .NUM_W (SW),
        .DEN_W (SW),
        .QB    (QB),
        .SB_W  (SBW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_valid),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_valid (w_d_valid),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_side  (w_d_side_bits)
    );

    assign w_d_side = w_d_side_bits;

    // distance limits and result
    logic                          w_rem_nz;
    logic signed [FLW-1:0]         w_tq;
    logic signed [FLW-1:0]         w_fl;
    logic signed [FLW-1:0]         w_min;
    logic signed [FLW-1:0]         w_max;
    logic                          w_hit;
    logic [rti_pkg::DIST_W-1:0]    w_tq_lo;

    assign w_rem_nz = w_rem[rti_pkg::LANE_T] != '0;
    assign w_tq     = signed'(FLW'(w_quot[rti_pkg::LANE_T]));
    assign w_fl     = w_d_side.tneg ? -w_tq - signed'(FLW'(w_rem_nz)) : w_tq;
    assign w_min    = FLW'(r_min_dist);
    assign w_max    = FLW'(r_max_dist);
    assign w_hit    = w_d_side.pass && (w_fl < w_max)
                      && ((w_fl > w_min) || ((w_fl == w_min) && w_rem_nz));
    assign w_tq_lo  = w_quot[rti_pkg::LANE_T][rti_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_hit_flag     <= w_hit;
            o_hit_distance <= !w_hit ? '0
                              : (w_d_side.tneg ? rti_pkg::DIST_W'(0) - w_tq_lo : w_tq_lo);
            o_bary_u       <= w_hit ? w_quot[rti_pkg::LANE_U][rti_pkg::UV_W-1:0] : '0;
            o_bary_v       <= w_hit ? w_quot[rti_pkg::LANE_V][rti_pkg::UV_W-1:0] : '0;
            o_result_tag   <= w_d_side.tag;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
